// ===== rtl/sle_pkg.sv =====
// ----------------------------------------------------------------------------
// Sequential list engine package
// Shared sizes, operation codes and the command and reply records that pass
// between the top level and the row of list cells.
// ----------------------------------------------------------------------------
package sle_pkg;

   localparam int CAPACITY   = 16;
   localparam int ELEM_WIDTH = 32;
   localparam int CNT_W      = $clog2(CAPACITY + 1);
   localparam int POS_W      = $clog2(CAPACITY);
   localparam int OP_W       = 3;

   localparam logic [OP_W-1:0] OP_CLEAR  = 3'd0;
   localparam logic [OP_W-1:0] OP_INSERT = 3'd1;
   localparam logic [OP_W-1:0] OP_DELETE = 3'd2;
   localparam logic [OP_W-1:0] OP_GET    = 3'd3;
   localparam logic [OP_W-1:0] OP_LOCATE = 3'd4;
   localparam logic [OP_W-1:0] OP_PRIOR  = 3'd5;
   localparam logic [OP_W-1:0] OP_NEXT   = 3'd6;

   typedef struct packed {
      logic                  compare_en;
      logic [ELEM_WIDTH-1:0] compare_value;
      logic [CNT_W-1:0]      count;
      logic [CNT_W-1:0]      idx;
      logic [ELEM_WIDTH-1:0] value;
      logic                  sel_index;
      logic                  sel_prior;
      logic                  sel_next;
      logic                  shift_up;
      logic                  shift_down;
   } cell_cmd_type;

   typedef struct packed {
      logic                  hit;
      logic [ELEM_WIDTH-1:0] value;
   } cell_rsp_type;

endpackage

// ===== rtl/sle_cell.sv =====
// ----------------------------------------------------------------------------
// Sequential list cell
// Holds one list entry, compares it against a searched word, and shifts
// entries to or from its neighbors on insert and delete.
// ----------------------------------------------------------------------------
module sle_cell import sle_pkg::*; (
   input  logic                  clock,
   input  cell_cmd_type          cmd,
   input  logic [CNT_W-1:0]      cell_pos,
   input  logic [ELEM_WIDTH-1:0] left_data,
   input  logic [ELEM_WIDTH-1:0] right_data,
   input  logic                  left_first,
   input  logic                  right_first,
   input  logic                  seen_in,
   output logic                  seen_out,
   output logic                  first_out,
   output logic [ELEM_WIDTH-1:0] data_out,
   output cell_rsp_type          rsp
);

   logic [ELEM_WIDTH-1:0] data_ff;
   logic [ELEM_WIDTH-1:0] data_in;
   logic                  match_ff;
   logic                  match_in;
   logic                  occupied;

   assign occupied  = cell_pos < cmd.count;
   assign match_in  = cmd.compare_en ? (occupied && (data_ff == cmd.compare_value)) : match_ff;
   assign first_out = match_ff & ~seen_in;
   assign seen_out  = seen_in | match_ff;
   assign data_out  = data_ff;

   always_comb begin
      data_in = data_ff;
      if (cmd.shift_up) begin
         if (cell_pos > cmd.idx) begin
            data_in = left_data;
         end else if (cell_pos == cmd.idx) begin
            data_in = cmd.value;
         end
      end else if (cmd.shift_down) begin
         if (cell_pos >= cmd.idx) begin
            data_in = right_data;
         end
      end
   end

   always_comb begin
      rsp.hit   = (cmd.sel_index && (cell_pos == cmd.idx) && occupied)
                || (cmd.sel_prior && right_first)
                || (cmd.sel_next && left_first && occupied);
      rsp.value = rsp.hit ? data_ff : '0;
   end

   always_ff @(posedge clock) begin
      data_ff  <= data_in;
      match_ff <= match_in;
   end

endmodule

// ===== rtl/sequential_list_engine_unit.sv =====
// ----------------------------------------------------------------------------
// Sequential list engine
// Ordered list held in a row of cells, one entry per cell, with a length
// count; supports clear, insert, delete, get, locate, prior and next.
// ----------------------------------------------------------------------------
// On accept the request is registered and every cell registers its equality
// compare against the searched word; once the output register is free, the
// first-match chain runs, the row shifts, and the result is registered and
// offered. No new transaction is taken until the current one is resolved.
// Reset clears the length and the control state; entry contents are not
// cleared.
// ----------------------------------------------------------------------------
module sequential_list_engine_unit import sle_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [OP_W-1:0]       req_opcode,
   input  logic [CNT_W-1:0]      req_item_index,
   input  logic [ELEM_WIDTH-1:0] req_item_value,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic                  rsp_ok,
   output logic [ELEM_WIDTH-1:0] rsp_out_value,
   output logic [POS_W-1:0]      rsp_out_index,
   output logic [CNT_W-1:0]      rsp_list_length,
   output logic                  rsp_is_empty
);

   logic                  busy_ff, busy_in;
   logic [CNT_W-1:0]      count_ff, count_in;
   logic [OP_W-1:0]       op_ff;
   logic [CNT_W-1:0]      idx_ff;
   logic [ELEM_WIDTH-1:0] value_ff;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  rsp_ok_ff;
   logic [ELEM_WIDTH-1:0] rsp_value_ff;
   logic [POS_W-1:0]      rsp_index_ff;
   logic [CNT_W-1:0]      rsp_length_ff;

   logic                  accept;
   logic                  commit;
   logic                  ins_ok;
   logic                  any_hit;
   logic [ELEM_WIDTH-1:0] hit_value;
   logic [POS_W-1:0]      loc_pos;
   logic                  res_ok;
   logic [ELEM_WIDTH-1:0] res_value;
   logic [POS_W-1:0]      res_index;
   logic [CNT_W-1:0]      res_count;

   cell_cmd_type          cmd;
   cell_rsp_type          cell_rsp [CAPACITY];
   logic [ELEM_WIDTH-1:0] cell_data [CAPACITY];
   logic [CAPACITY-1:0]   first_vec;
   logic [CAPACITY:0]     seen_chain;

   assign accept    = req_valid & ~req_stall;
   assign req_stall = busy_ff;
   assign commit    = busy_ff & (~rsp_valid_ff | ~rsp_stall);
   assign ins_ok    = (count_ff < CNT_W'(CAPACITY)) && (idx_ff <= count_ff);

   always_comb begin
      cmd.compare_en    = accept;
      cmd.compare_value = req_item_value;
      cmd.count         = count_ff;
      cmd.idx           = idx_ff;
      cmd.value         = value_ff;
      cmd.sel_index     = (op_ff == OP_DELETE) || (op_ff == OP_GET);
      cmd.sel_prior     = op_ff == OP_PRIOR;
      cmd.sel_next      = op_ff == OP_NEXT;
      cmd.shift_up      = commit && (op_ff == OP_INSERT) && ins_ok;
      cmd.shift_down    = commit && (op_ff == OP_DELETE) && any_hit;
   end

   assign seen_chain[0] = 1'b0;

   for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
      logic [ELEM_WIDTH-1:0] left_data;
      logic [ELEM_WIDTH-1:0] right_data;
      logic                  left_first;
      logic                  right_first;

      if (k == 0) begin : g_head
         assign left_data  = '0;
         assign left_first = 1'b0;
      end else begin : g_body
         assign left_data  = cell_data[k-1];
         assign left_first = first_vec[k-1];
      end

      if (k == CAPACITY - 1) begin : g_tail
         assign right_data  = '0;
         assign right_first = 1'b0;
      end else begin : g_inner
         assign right_data  = cell_data[k+1];
         assign right_first = first_vec[k+1];
      end

      sle_cell u_cell (
         .clock       (clock),
         .cmd         (cmd),
         .cell_pos    (CNT_W'(k)),
         .left_data   (left_data),
         .right_data  (right_data),
         .left_first  (left_first),
         .right_first (right_first),
         .seen_in     (seen_chain[k]),
         .seen_out    (seen_chain[k+1]),
         .first_out   (first_vec[k]),
         .data_out    (cell_data[k]),
         .rsp         (cell_rsp[k])
      );
   end

   always_comb begin
      any_hit   = 1'b0;
      hit_value = '0;
      loc_pos   = '0;
      for (int k = 0; k < CAPACITY; k++) begin
         any_hit   = any_hit | cell_rsp[k].hit;
         hit_value = hit_value | cell_rsp[k].value;
         if (first_vec[k]) begin
            loc_pos = loc_pos | POS_W'(k);
         end
      end
   end

   always_comb begin
      res_ok    = 1'b0;
      res_value = '0;
      res_index = '0;
      res_count = count_ff;
      unique case (op_ff)
         OP_CLEAR: begin
            res_ok    = 1'b1;
            res_count = '0;
         end
         OP_INSERT: begin
            res_ok = ins_ok;
            if (ins_ok) begin
               res_count = count_ff + CNT_W'(1);
            end
         end
         OP_DELETE: begin
            res_ok    = any_hit;
            res_value = hit_value;
            if (any_hit) begin
               res_count = count_ff - CNT_W'(1);
            end
         end
         OP_GET, OP_PRIOR, OP_NEXT: begin
            res_ok    = any_hit;
            res_value = hit_value;
         end
         OP_LOCATE: begin
            res_ok    = |first_vec;
            res_index = loc_pos;
         end
         default: begin
            res_ok = 1'b0;
         end
      endcase
   end

   assign busy_in      = accept | (busy_ff & ~commit);
   assign count_in     = commit ? res_count : count_ff;
   assign rsp_valid_in = commit | (rsp_valid_ff & rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff    <= req_opcode;
         idx_ff   <= req_item_index;
         value_ff <= req_item_value;
      end
      if (commit) begin
         rsp_ok_ff     <= res_ok;
         rsp_value_ff  <= res_value;
         rsp_index_ff  <= res_index;
         rsp_length_ff <= res_count;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_ok          = rsp_ok_ff;
   assign rsp_out_value   = rsp_value_ff;
   assign rsp_out_index   = rsp_index_ff;
   assign rsp_list_length = rsp_length_ff;
   assign rsp_is_empty    = rsp_length_ff == '0;

   // The length never exceeds the number of cells.
   assert property (@(posedge clock) disable iff (reset) count_ff <= CNT_W'(CAPACITY))
      else $error("list length exceeds capacity");

   // The first-match chain marks at most one cell.
   assert property (@(posedge clock) disable iff (reset) busy_ff |-> $onehot0(first_vec))
      else $error("more than one first match");

   // A resolved transaction always shows up on the result channel.
   assert property (@(posedge clock) disable iff (reset) commit |=> rsp_valid_ff)
      else $error("resolved transaction not presented");

   // A successful insert grows the list by exactly one entry.
   assert property (@(posedge clock) disable iff (reset)
      (commit && (op_ff == OP_INSERT) && ins_ok) |=> (count_ff == $past(count_ff) + CNT_W'(1)))
      else $error("insert did not grow the list");

   // No new transaction is taken while one is still being resolved.
   assert property (@(posedge clock) disable iff (reset) (busy_ff && !commit) |=> !accept)
      else $error("transaction accepted while busy");

endmodule
